// File: design/uvs_pkg.sv
`default_nettype none
package uvs_pkg;

    localparam int MAX_RINGS   = 256;
    localparam int MAX_SECTORS = 256;

    // apb address width and register codes
    localparam int ADDR_W = 5;
    localparam logic [2:0] REG_CENTER_X     = 3'd0;
    localparam logic [2:0] REG_CENTER_Y     = 3'd1;
    localparam logic [2:0] REG_CENTER_Z     = 3'd2;
    localparam logic [2:0] REG_RADIUS       = 3'd3;
    localparam logic [2:0] REG_RING_COUNT   = 3'd4;
    localparam logic [2:0] REG_SECTOR_COUNT = 3'd5;

    // pipeline depths
    localparam int DIV_STAGES = 17;
    localparam int SIN_STAGES = 5;
    localparam int POS_STAGES = 3;
    localparam int PIPE_DEPTH = DIV_STAGES + SIN_STAGES + POS_STAGES;

    typedef struct packed {
        logic [31:0] center_x;
        logic [31:0] center_y;
        logic [31:0] center_z;
        logic [30:0] radius;
        logic [8:0]  ring_count;
        logic [8:0]  sector_count;
    } cfg_t;

    // one lane of the restoring divider
    typedef struct packed {
        logic [9:0]  rem;
        logic [16:0] low;
        logic [16:0] quo;
        logic [9:0]  den;
    } div_lane_t;

    // per-request data carried beside the arithmetic
    typedef struct packed {
        logic        in_range;
        logic        quad_valid;
        logic [16:0] corner_a;
        logic [16:0] corner_b;
        logic [16:0] corner_c;
        logic [16:0] corner_d;
    } side_t;

    function automatic div_lane_t div_step(div_lane_t l);
        logic [10:0] t;
        div_lane_t   n;
        n = l;
        t = {l.rem, l.low[16]};
        n.low = {l.low[15:0], 1'b0};
        if (t >= {1'b0, l.den})
        begin
            n.rem = 10'(t - {1'b0, l.den});
            n.quo = {l.quo[15:0], 1'b1};
        end
        else
        begin
            n.rem = t[9:0];
            n.quo = {l.quo[15:0], 1'b0};
        end
        return n;
    endfunction

    function automatic logic [8:0] clamp_count(logic [8:0] c, logic [8:0] maxc);
        logic [8:0] r;
        if (c == 9'd0)
            r = 9'd1;
        else if (c > maxc)
            r = maxc;
        else
            r = c;
        return r;
    endfunction

endpackage
`default_nettype wire

// File: design/uvs_cfg_regs.sv
`default_nettype none
module uvs_cfg_regs (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [uvs_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output uvs_pkg::cfg_t                   cfg
);

    uvs_pkg::cfg_t cfg_reg;
    uvs_pkg::cfg_t cfg_next;
    logic [2:0]    idx;

    assign idx = paddr[4:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite)
        begin
            case (idx)
                uvs_pkg::REG_CENTER_X:     cfg_next.center_x = pwdata;
                uvs_pkg::REG_CENTER_Y:     cfg_next.center_y = pwdata;
                uvs_pkg::REG_CENTER_Z:     cfg_next.center_z = pwdata;
                uvs_pkg::REG_RADIUS:       cfg_next.radius = pwdata[30:0];
                uvs_pkg::REG_RING_COUNT:   cfg_next.ring_count = pwdata[8:0];
                uvs_pkg::REG_SECTOR_COUNT: cfg_next.sector_count = pwdata[8:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center_x     <= '0;
            cfg_reg.center_y     <= '0;
            cfg_reg.center_z     <= '0;
            cfg_reg.radius       <= 31'd65536;
            cfg_reg.ring_count   <= 9'd16;
            cfg_reg.sector_count <= 9'd16;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (idx)
            uvs_pkg::REG_CENTER_X:     prdata = cfg_reg.center_x;
            uvs_pkg::REG_CENTER_Y:     prdata = cfg_reg.center_y;
            uvs_pkg::REG_CENTER_Z:     prdata = cfg_reg.center_z;
            uvs_pkg::REG_RADIUS:       prdata = {1'b0, cfg_reg.radius};
            uvs_pkg::REG_RING_COUNT:   prdata = {23'd0, cfg_reg.ring_count};
            uvs_pkg::REG_SECTOR_COUNT: prdata = {23'd0, cfg_reg.sector_count};
            default:                   prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

// File: design/uvs_angle_div.sv
`default_nettype none
module uvs_angle_div (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [25:0] num_phi,
    input  wire logic [25:0] num_theta,
    input  wire logic [9:0]  den_phi,
    input  wire logic [9:0]  den_theta,
    output logic [15:0]      phi,
    output logic [15:0]      theta
);

    uvs_pkg::div_lane_t ph_reg  [uvs_pkg::DIV_STAGES];
    uvs_pkg::div_lane_t th_reg  [uvs_pkg::DIV_STAGES];
    uvs_pkg::div_lane_t ph_next [uvs_pkg::DIV_STAGES];
    uvs_pkg::div_lane_t th_next [uvs_pkg::DIV_STAGES];
    uvs_pkg::div_lane_t ph_init;
    uvs_pkg::div_lane_t th_init;

    // top numerator bits stay below the divisor, so 17 quotient bits suffice
    assign ph_init = '{rem: {1'b0, num_phi[25:17]}, low: num_phi[16:0],
                       quo: '0, den: den_phi};
    assign th_init = '{rem: {1'b0, num_theta[25:17]}, low: num_theta[16:0],
                       quo: '0, den: den_theta};

    for (genvar k = 0; k < uvs_pkg::DIV_STAGES; k++)
    begin : g_step
        if (k == 0)
        begin : g_first
            always_comb
            begin
                ph_next[k] = uvs_pkg::div_step(ph_init);
                th_next[k] = uvs_pkg::div_step(th_init);
            end
        end
        else
        begin : g_rest
            always_comb
            begin
                ph_next[k] = uvs_pkg::div_step(ph_reg[k-1]);
                th_next[k] = uvs_pkg::div_step(th_reg[k-1]);
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ph_reg[k] <= ph_next[k];
                th_reg[k] <= th_next[k];
            end
        end
    end

    // theta wraps at a full turn
    assign phi   = ph_reg[uvs_pkg::DIV_STAGES-1].quo[15:0];
    assign theta = th_reg[uvs_pkg::DIV_STAGES-1].quo[15:0];

endmodule
`default_nettype wire

// File: design/uvs_sine.sv
`default_nettype none
module uvs_sine (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [15:0] angle,
    output logic signed [15:0] sine
);

    localparam logic [31:0] C1 = 32'd51472;
    localparam logic [31:0] C3 = 32'd21024;
    localparam logic [31:0] C5 = 32'd2320;

    logic [14:0] fx;
    logic [15:0] x_next;
    logic [31:0] sq_next;
    logic [15:0] x_reg1, x_reg2, x_reg3;
    logic [31:0] sq_reg;
    logic        neg_reg1, neg_reg2, neg_reg3, neg_reg4;
    logic [15:0] x2_next, x2_reg;
    logic [31:0] cube_next, cube_reg;
    logic [15:0] x3_next, x3_reg;
    logic [31:0] p5_next, p5_reg;
    logic [15:0] x5_next;
    logic [31:0] t1_reg, t3_reg, t5_reg;
    logic [33:0] sum;
    logic [14:0] mag;
    logic signed [15:0] sine_next, sine_reg;

    // fold into the first quadrant
    assign fx      = angle[14] ? 15'(15'd16384 - {1'b0, angle[13:0]}) : {1'b0, angle[13:0]};
    assign x_next  = {fx, 1'b0};
    assign sq_next = 32'(x_next) * 32'(x_next);

    assign x2_next   = 16'((sq_reg + 32'd16384) >> 15);
    assign cube_next = 32'(x2_next) * 32'(x_reg1);

    assign x3_next = 16'((cube_reg + 32'd16384) >> 15);
    assign p5_next = 32'(x3_next) * 32'(x2_reg);

    assign x5_next = 16'((p5_reg + 32'd16384) >> 15);

    assign sum = {2'b00, t1_reg} + {2'b00, t5_reg} + 34'd16384 - {2'b00, t3_reg};
    assign mag = (sum[33] || (sum[32:30] != 3'd0)) ? 15'h7fff : sum[29:15];
    assign sine_next = neg_reg4 ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg1   <= x_next;
            sq_reg   <= sq_next;
            neg_reg1 <= angle[15];

            x_reg2   <= x_reg1;
            x2_reg   <= x2_next;
            cube_reg <= cube_next;
            neg_reg2 <= neg_reg1;

            x_reg3   <= x_reg2;
            x3_reg   <= x3_next;
            p5_reg   <= p5_next;
            neg_reg3 <= neg_reg2;

            t1_reg   <= C1 * 32'(x_reg3);
            t3_reg   <= C3 * 32'(x3_reg);
            t5_reg   <= C5 * 32'(x5_next);
            neg_reg4 <= neg_reg3;

            sine_reg <= sine_next;
        end
    end

    assign sine = sine_reg;

endmodule
`default_nettype wire

// File: design/uv_sphere_tessellator.sv
`default_nettype none
// channel  | handshake                   | payload
// ---------+-----------------------------+-------------------------------------------
// request  | in_valid / in_ready         | ring_index, sector_index
// vertex   | out_valid / out_ready       | pos_x/y/z, in_range, quad_valid, corner_a..d
// config   | psel penable pwrite pready  | paddr, pwdata, prdata
//
// one request per clock sustained while no finished vertex is held; 25 register stages,
// and a vertex is valid when its request reaches the last of them
// 17 stages are the bit-per-stage angle dividers, 5 the polynomial sine, 3 scaling
// the whole pipe advances together; a stalled vertex freezes every stage
// rst_n clears the valid bits and loads the register reset values
module uv_sphere_tessellator (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [uvs_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [8:0]                 ring_index,
    input  wire logic [8:0]                 sector_index,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic signed [31:0]              pos_x,
    output logic signed [31:0]              pos_y,
    output logic signed [31:0]              pos_z,
    output logic                            in_range,
    output logic                            quad_valid,
    output logic [16:0]                     corner_a,
    output logic [16:0]                     corner_b,
    output logic [16:0]                     corner_c,
    output logic [16:0]                     corner_d
);

    localparam int LAST = uvs_pkg::PIPE_DEPTH - 1;
    localparam int SIN_OUT = uvs_pkg::DIV_STAGES + uvs_pkg::SIN_STAGES - 1;

    uvs_pkg::cfg_t cfg;
    logic          en;

    logic [uvs_pkg::PIPE_DEPTH-1:0] v_reg;
    logic [uvs_pkg::PIPE_DEPTH-1:0] v_next;
    uvs_pkg::side_t side_reg [uvs_pkg::PIPE_DEPTH];
    uvs_pkg::side_t side_next;

    // clamped counts
    logic [8:0]  rc, sc;
    logic [9:0]  sc1;
    logic [25:0] num_phi, num_theta;
    logic [18:0] a_full;
    logic [16:0] a_val, c_val;
    logic        rng, qv;

    logic [15:0] phi, theta;
    logic signed [15:0] sp, cp, st, ct;

    // scaling stages
    logic signed [30:0] spct_next, spst_next, spct_reg, spst_reg;
    logic signed [15:0] cp_reg;
    logic signed [31:0] rad_s;
    logic signed [61:0] mx_next, mz_next, mx_reg, mz_reg;
    logic signed [47:0] my_next, my_reg;
    logic signed [61:0] mx_rnd, mz_rnd;
    logic signed [47:0] my_rnd;
    logic [31:0] px_next, py_next, pz_next;
    logic [31:0] px_reg, py_reg, pz_reg;

    uvs_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    assign pready = 1'b1;

    // whole pipe moves unless a finished vertex is held
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    assign rc  = uvs_pkg::clamp_count(cfg.ring_count, 9'(uvs_pkg::MAX_RINGS));
    assign sc  = uvs_pkg::clamp_count(cfg.sector_count, 9'(uvs_pkg::MAX_SECTORS));
    assign sc1 = 10'(sc) + 10'd1;

    // phi = (r*2^16 + R) / 2R, theta = (s*2^17 + S) / 2S
    assign num_phi   = {1'b0, ring_index, 16'd0} + 26'(rc);
    assign num_theta = {sector_index, 17'd0} + 26'(sc);

    assign rng    = (ring_index <= rc) && (sector_index <= sc);
    assign qv     = (ring_index < rc) && (sector_index < sc);
    assign a_full = 19'(ring_index) * 19'(sc1) + 19'(sector_index);
    assign a_val  = a_full[16:0];
    assign c_val  = 17'(a_val + 17'(sc1));

    // corners read zero when there is no quad
    always_comb
    begin
        side_next.in_range   = rng;
        side_next.quad_valid = qv;
        side_next.corner_a   = qv ? a_val : '0;
        side_next.corner_b   = qv ? 17'(a_val + 17'd1) : '0;
        side_next.corner_c   = qv ? c_val : '0;
        side_next.corner_d   = qv ? 17'(c_val + 17'd1) : '0;
    end

    assign v_next = {v_reg[uvs_pkg::PIPE_DEPTH-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= v_next;
        end
    end

    // side data rides along the same stages
    for (genvar k = 0; k < uvs_pkg::PIPE_DEPTH; k++)
    begin : g_side
        if (k == 0)
        begin : g_first
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    side_reg[k] <= side_next;
                end
            end
        end
        else
        begin : g_rest
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    side_reg[k] <= side_reg[k-1];
                end
            end
        end
    end

    uvs_angle_div u_div (
        .clk       (clk),
        .en        (en),
        .num_phi   (num_phi),
        .num_theta (num_theta),
        .den_phi   ({rc, 1'b0}),
        .den_theta ({sc, 1'b0}),
        .phi       (phi),
        .theta     (theta)
    );

    // cosine is the sine a quarter turn on
    uvs_sine u_sin_phi (
        .clk   (clk),
        .en    (en),
        .angle (phi),
        .sine  (sp)
    );

    uvs_sine u_cos_phi (
        .clk   (clk),
        .en    (en),
        .angle (16'(phi + 16'd16384)),
        .sine  (cp)
    );

    uvs_sine u_sin_theta (
        .clk   (clk),
        .en    (en),
        .angle (theta),
        .sine  (st)
    );

    uvs_sine u_cos_theta (
        .clk   (clk),
        .en    (en),
        .angle (16'(theta + 16'd16384)),
        .sine  (ct)
    );

    // stage one: direction products in q1.30
    assign spct_next = 31'(sp * ct);
    assign spst_next = 31'(sp * st);

    // stage two: scale by the radius
    assign rad_s   = $signed({1'b0, cfg.radius});
    assign mx_next = 62'(rad_s) * 62'(spct_reg);
    assign mz_next = 62'(rad_s) * 62'(spst_reg);
    assign my_next = 48'(rad_s) * 48'(cp_reg);

    // stage three: round half up, add center, wrap to 32 bits; zero when out of range
    assign mx_rnd = mx_reg + 62'sd536870912;
    assign mz_rnd = mz_reg + 62'sd536870912;
    assign my_rnd = my_reg + 48'sd16384;

    assign px_next = side_reg[LAST-1].in_range ? 32'(cfg.center_x + mx_rnd[61:30]) : '0;
    assign py_next = side_reg[LAST-1].in_range ? 32'(cfg.center_y + my_rnd[46:15]) : '0;
    assign pz_next = side_reg[LAST-1].in_range ? 32'(cfg.center_z + mz_rnd[61:30]) : '0;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            spct_reg <= spct_next;
            spst_reg <= spst_next;
            cp_reg   <= cp;
            mx_reg   <= mx_next;
            mz_reg   <= mz_next;
            my_reg   <= my_next;
            px_reg   <= px_next;
            py_reg   <= py_next;
            pz_reg   <= pz_next;
        end
    end

    assign out_valid  = v_reg[LAST];
    assign pos_x      = $signed(px_reg);
    assign pos_y      = $signed(py_reg);
    assign pos_z      = $signed(pz_reg);
    assign in_range   = side_reg[LAST].in_range;
    assign quad_valid = side_reg[LAST].quad_valid;
    assign corner_a   = side_reg[LAST].corner_a;
    assign corner_b   = side_reg[LAST].corner_b;
    assign corner_c   = side_reg[LAST].corner_c;
    assign corner_d   = side_reg[LAST].corner_d;

    // out-of-range points carry no geometry
    a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !in_range |->
            pos_x == 32'sd0 && pos_y == 32'sd0 && pos_z == 32'sd0 && !quad_valid)
        else $error("out-of-range vertex with nonzero payload");

    // a quad lies inside the grid and its corners pair up
    a_quad_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && quad_valid |->
            in_range && corner_b == 17'(corner_a + 17'd1)
            && corner_d == 17'(corner_c + 17'd1))
        else $error("quad corners inconsistent");

    // a held vertex freezes every valid bit
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(v_reg))
        else $error("pipeline moved during stall");

    // an accepted request occupies the first stage
    a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> v_reg[0])
        else $error("accepted request lost at entry");

    // a request leaving the sine stages moves on to scaling
    a_sine_stage: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[SIN_OUT] && en |=> v_reg[SIN_OUT+1])
        else $error("request dropped after sine stage");

endmodule
`default_nettype wire

// File: bench/tb_uv_sphere_tessellator.sv
`timescale 1ns / 1ps
`default_nettype none

// expected vertex record
typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic        in_range;
    logic        quad_valid;
    logic [16:0] corner_a;
    logic [16:0] corner_b;
    logic [16:0] corner_c;
    logic [16:0] corner_d;
} vertex_t;

class vertex_scoreboard;
    // shadow registers
    logic [31:0] cx, cy, cz;
    logic [30:0] radius;
    logic [8:0]  rings, sectors;
    vertex_t     pending_vertices[$];
    int          mismatches;

    function void set_defaults();
        cx = 0;
        cy = 0;
        cz = 0;
        radius = 31'd65536;
        rings = 9'd16;
        sectors = 9'd16;
    endfunction

    // polynomial sine on one quadrant, q1.15
    function longint quadrant_sine(longint f);
        longint x, x2, x3, x5, y;
        x = f * 2;
        x2 = (x * x + 16384) >>> 15;
        x3 = (x2 * x + 16384) >>> 15;
        x5 = (x3 * x2 + 16384) >>> 15;
        y = (51472 * x + 2320 * x5 + 16384 - 21024 * x3) >>> 15;
        if (y > 32767)
            y = 32767;
        return y;
    endfunction

    function longint angle_sine(logic [15:0] t);
        longint v;
        v = t[14] ? quadrant_sine(16384 - longint'(t[13:0])) : quadrant_sine(longint'(t[13:0]));
        return t[15] ? -v : v;
    endfunction

    // floor((v + half) / 2^k), arithmetic shift floors
    function longint round_floor(longint v, int k);
        return (v + (longint'(1) << (k - 1))) >>> k;
    endfunction

    function longint effective_count(logic [8:0] c, int maxc);
        if (c == 0)
            return 1;
        if (c > maxc)
            return maxc;
        return c;
    endfunction

    function void note_request(logic [8:0] r, logic [8:0] s);
        vertex_t     v;
        longint      rc, sc, sp, cp, st, ct, rad, a, c;
        logic [15:0] phi, theta;
        v = '0;
        rc = effective_count(rings, uvs_pkg::MAX_RINGS);
        sc = effective_count(sectors, uvs_pkg::MAX_SECTORS);
        if (r <= rc && s <= sc)
        begin
            phi = 16'((longint'(r) * 65536 + rc) / (2 * rc));
            theta = 16'((longint'(s) * 131072 + sc) / (2 * sc));
            sp = angle_sine(phi);
            cp = angle_sine(phi + 16'd16384);
            st = angle_sine(theta);
            ct = angle_sine(theta + 16'd16384);
            rad = longint'(radius);
            v.pos_x = 32'(longint'($signed(cx)) + round_floor(rad * (sp * ct), 30));
            v.pos_y = 32'(longint'($signed(cy)) + round_floor(rad * cp, 15));
            v.pos_z = 32'(longint'($signed(cz)) + round_floor(rad * (sp * st), 30));
            v.in_range = 1'b1;
            if (r < rc && s < sc)
            begin
                a = longint'(r) * (sc + 1) + s;
                c = (longint'(r) + 1) * (sc + 1) + s;
                v.quad_valid = 1'b1;
                v.corner_a = 17'(a);
                v.corner_b = 17'(a + 1);
                v.corner_c = 17'(c);
                v.corner_d = 17'(c + 1);
            end
        end
        pending_vertices = {pending_vertices, v};
    endfunction

    function void check_vertex(vertex_t got);
        vertex_t want;
        if (pending_vertices.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected vertex %h", got);
            return;
        end
        want = pending_vertices.pop_front();
        if (got.pos_x !== want.pos_x || got.pos_y !== want.pos_y ||
            got.pos_z !== want.pos_z || got.in_range !== want.in_range ||
            got.quad_valid !== want.quad_valid || got.corner_a !== want.corner_a ||
            got.corner_b !== want.corner_b || got.corner_c !== want.corner_c ||
            got.corner_d !== want.corner_d)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("vertex mismatch: expected %h actual %h", want, got);
        end
    endfunction
endclass

module tb_uv_sphere_tessellator;

    logic                        clk;
    logic                        rst_n;
    logic                        psel, penable, pwrite;
    logic [uvs_pkg::ADDR_W-1:0]  paddr;
    logic [31:0]                 pwdata;
    logic [31:0]                 prdata;
    logic                        pready;
    logic                        in_valid, in_ready;
    logic [8:0]                  ring_index, sector_index;
    logic                        out_valid, out_ready;
    logic signed [31:0]          pos_x, pos_y, pos_z;
    logic                        in_range, quad_valid;
    logic [16:0]                 corner_a, corner_b, corner_c, corner_d;

    vertex_scoreboard    board;
    longint              cycle_count;
    bit                  sink_idle_allowed;  // random gaps on the vertex side
    bit                  source_idle_allowed;
    int                  hold_off_cycles;    // long stall requested from the sink

    uv_sphere_tessellator dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready),
        .ring_index(ring_index), .sector_index(sector_index),
        .out_valid(out_valid), .out_ready(out_ready),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .in_range(in_range), .quad_valid(quad_valid),
        .corner_a(corner_a), .corner_b(corner_b),
        .corner_c(corner_c), .corner_d(corner_d)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #1 clk = ~clk;
    end

    // watchdog: the slowest correct run is far below this
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > 400000)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // vertex sink: compare on every accepted vertex
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_vertex({pos_x, pos_y, pos_z, in_range, quad_valid,
                                corner_a, corner_b, corner_c, corner_d});
    end

    // sink ready pattern: random bursts of stall, or a long hold-off on demand
    initial
    begin
        int gap;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off_cycles > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold_off_cycles) @(posedge clk);
                hold_off_cycles = 0;
            end
            else if (sink_idle_allowed && $urandom_range(0, 5) == 0)
            begin
                gap = $urandom_range(1, 11);
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // one apb write: setup then access, then back to idle
    task automatic write_register(logic [2:0] reg_code, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= uvs_pkg::ADDR_W'(reg_code) << 2;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (reg_code)
            uvs_pkg::REG_CENTER_X:     board.cx = value;
            uvs_pkg::REG_CENTER_Y:     board.cy = value;
            uvs_pkg::REG_CENTER_Z:     board.cz = value;
            uvs_pkg::REG_RADIUS:       board.radius = value[30:0];
            uvs_pkg::REG_RING_COUNT:   board.rings = value[8:0];
            uvs_pkg::REG_SECTOR_COUNT: board.sectors = value[8:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_sphere(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                              logic [31:0] rad, logic [31:0] nr, logic [31:0] ns);
        write_register(uvs_pkg::REG_CENTER_X, x);
        write_register(uvs_pkg::REG_CENTER_Y, y);
        write_register(uvs_pkg::REG_CENTER_Z, z);
        write_register(uvs_pkg::REG_RADIUS, rad);
        write_register(uvs_pkg::REG_RING_COUNT, nr);
        write_register(uvs_pkg::REG_SECTOR_COUNT, ns);
    endtask

    // offer one grid point, optionally after a random idle burst
    task automatic send_point(logic [8:0] r, logic [8:0] s);
        if (source_idle_allowed && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_valid <= 1'b1;
        ring_index <= r;
        sector_index <= s;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_request(r, s);
    endtask

    task automatic drain_vertices();
        while (board.pending_vertices.size() != 0)
            @(posedge clk);
        repeat (uvs_pkg::PIPE_DEPTH + 5) @(posedge clk);
    endtask

    // mostly valid points with a few beyond the counts
    task automatic random_points(int n);
        int rmax, smax;
        rmax = board.effective_count(board.rings, uvs_pkg::MAX_RINGS);
        smax = board.effective_count(board.sectors, uvs_pkg::MAX_SECTORS);
        repeat (n)
        begin
            if ($urandom_range(0, 9) == 0)
                send_point(9'($urandom), 9'($urandom));
            else
                send_point(9'($urandom_range(0, rmax)), 9'($urandom_range(0, smax)));
        end
    endtask

    initial
    begin
        board = new();
        board.set_defaults();
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        ring_index = '0;
        sector_index = '0;
        sink_idle_allowed = 1'b0;
        source_idle_allowed = 1'b0;
        hold_off_cycles = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset settings, poles, seam, edges, out of range
        send_point(0, 0);
        send_point(16, 16);
        send_point(8, 4);
        send_point(15, 15);
        send_point(16, 0);
        send_point(0, 16);
        send_point(17, 0);
        send_point(0, 17);
        send_point(9'h1FF, 9'h1FF);
        send_point(5, 11);
        in_valid <= 1'b0;
        drain_vertices();

        // zero counts act as one, extreme centers and radius
        set_sphere(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 0, 0);
        send_point(0, 0);
        send_point(1, 1);
        send_point(1, 0);
        send_point(2, 0);
        send_point(0, 1);
        in_valid <= 1'b0;
        drain_vertices();

        // counts above the maximum clamp, full grid size
        set_sphere(32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 9'h1FF, 9'h1FF);
        send_point(256, 256);
        send_point(255, 255);
        send_point(256, 0);
        send_point(128, 64);
        send_point(257, 3);
        in_valid <= 1'b0;
        drain_vertices();

        // random: several settings with idle bursts on both sides
        sink_idle_allowed = 1'b1;
        source_idle_allowed = 1'b1;
        set_sphere(32'h0001_0000, 32'hFFFE_0000, 32'h0000_8000, 32'h0003_0000, 256, 256);
        random_points(150);
        in_valid <= 1'b0;
        drain_vertices();

        set_sphere($urandom, $urandom, $urandom, $urandom, 1, 1);
        random_points(100);
        in_valid <= 1'b0;
        drain_vertices();

        set_sphere($urandom, $urandom, $urandom, 32'h7FFF_FFFF,
                   $urandom_range(2, 40), $urandom_range(3, 40));
        // long sink stall while requests keep coming, so the pipe backs up
        hold_off_cycles = 120;
        random_points(150);
        in_valid <= 1'b0;
        drain_vertices();

        set_sphere($urandom, $urandom, $urandom, $urandom,
                   $urandom_range(0, 511), $urandom_range(0, 511));
        random_points(150);
        in_valid <= 1'b0;
        drain_vertices();

        // last part: no idling either side
        sink_idle_allowed = 1'b0;
        source_idle_allowed = 1'b0;
        set_sphere($urandom, $urandom, $urandom, $urandom,
                   $urandom_range(1, 256), $urandom_range(1, 256));
        random_points(150);
        in_valid <= 1'b0;
        drain_vertices();

        if (board.mismatches == 0 && board.pending_vertices.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

`default_nettype wire
